### rtl/rv64_pkg.sv
// Shared types and constants for the RV64 subset decode/execute block.
// No dependencies.
`default_nettype none
package rv64_pkg;

  localparam int XLEN = 64;
  localparam int NUM_REGS = 32;
  localparam logic [63:0] RESET_PC = 64'h0000_0000_8000_0000;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPIMMW = 7'h1B;
  localparam logic [6:0] OPC_OPW    = 7'h3B;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  localparam logic [1:0] ST_NORMAL  = 2'd0;
  localparam logic [1:0] ST_EBREAK  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [31:0] instruction;
    logic [63:0] load_data;
  } in_word_t;

  typedef struct packed {
    logic [63:0] inst_pc;
    logic [63:0] next_pc;
    logic [1:0]  mem_op;
    logic [63:0] mem_addr;
    logic [3:0]  mem_size;
    logic [63:0] mem_wdata;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [63:0] reg_value;
    logic [1:0]  status;
    logic [63:0] trap_code;
  } out_word_t;

  // classified word passed from front to back
  typedef struct packed {
    logic        mode;
    logic [31:0] instruction;
    logic [63:0] load_data;
    logic        is_ebreak;
    logic        legal;
  } dec_word_t;

endpackage
`default_nettype wire

### rtl/rv64_front.sv
// Front end: accepts input words, checks legality, pushes into a two-entry queue.
// Depends on rv64_pkg.
`default_nettype none
module rv64_front
  import rv64_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           q_valid,
  input  wire logic      q_pop,
  output dec_word_t      q_head
);

  dec_word_t   mem [2];
  logic        wptr, rptr;
  logic [1:0]  count;
  dec_word_t   d;
  logic        push;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;

  always_comb begin
    opc = in_word.instruction[6:0];
    f3  = in_word.instruction[14:12];
    f7  = in_word.instruction[31:25];
    d.mode = in_word.mode;
    d.instruction = in_word.instruction;
    d.load_data = in_word.load_data;
    d.is_ebreak = in_word.instruction == WORD_EBREAK;
    unique case (opc)
      OPC_LUI, OPC_AUIPC, OPC_JAL: d.legal = 1'b1;
      OPC_JALR:   d.legal = f3 == 3'd0;
      OPC_BRANCH: d.legal = f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd5;
      OPC_LOAD, OPC_STORE: d.legal = f3 == 3'd2 || f3 == 3'd3;
      OPC_OPIMM:  d.legal = f3 == 3'd0 || f3 == 3'd3 || f3 == 3'd7;
      OPC_OP:     d.legal = f7 == 7'h20 && f3 == 3'd0;
      OPC_OPIMMW: d.legal = f3 == 3'd0;
      OPC_OPW:    d.legal = (f7 == 7'h00 && f3 == 3'd0) || (f7 == 7'h01 && f3 == 3'd0)
                            || (f7 == 7'h01 && f3 == 3'd6);
      default:    d.legal = 1'b0;
    endcase
  end

  assign in_stall = count == 2'd2;
  assign push     = in_valid && !in_stall;
  assign q_valid  = count != 2'd0;
  assign q_head   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> count == $past(count) + 2'd1)
    else $error("count not tracking push");

endmodule
`default_nettype wire

### rtl/rv64_div.sv
// Iterative signed 32-bit remainder unit, one quotient bit per cycle.
// Depends on nothing beyond its ports.
`default_nettype none
module rv64_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      rem
);

  logic [31:0] q, r, dv;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {r, q[31]} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
        q <= dividend[31] ? -dividend : dividend;
        dv <= divisor[31] ? -divisor : divisor;
        neg <= dividend[31];
        r <= 32'd0;
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          rem <= neg ? -r : r;
        end else begin
          cnt <= cnt - 6'd1;
          q <= {q[30:0], 1'b0};
          if (!trial[32]) r <= trial[31:0];
          else r <= {r[30:0], q[31]};
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/rv64_back.sv
// Back end: register file, pc, execution sequencer and output register.
// Depends on rv64_pkg and rv64_div.
`default_nettype none
module rv64_back
  import rv64_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [XLEN-1:0] reset_pc,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire dec_word_t       q_head,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_word_t            out_word
);

  localparam int RW = $clog2(NUM_REGS);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_CLEAR} state_t;
  state_t state;

  logic [XLEN-1:0] rf [NUM_REGS];
  logic [XLEN-1:0] pc, s1, s2, a0;
  logic            halted, load_pending, load_is_word;
  logic [RW-1:0]   load_dest;
  logic [RW-1:0]   clr_idx;
  dec_word_t       cur;
  out_word_t       o;
  logic            we;
  logic [RW-1:0]   widx;
  logic [XLEN-1:0] wval;
  logic [63:0]     mul_p;
  logic            div_start, div_done;
  logic [31:0]     div_rem;
  logic            div_go;

  logic [31:0] w;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [XLEN-1:0] immi, imms, immb, immj, immu, npc;

  assign w  = cur.instruction;
  assign rd = w[11:7];
  assign f3 = w[14:12];
  assign immi = {{(XLEN-12){w[31]}}, w[31:20]};
  assign imms = {{(XLEN-12){w[31]}}, w[31:25], w[11:7]};
  assign immb = {{(XLEN-13){w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign immj = {{(XLEN-21){w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign immu = {{(XLEN-32){w[31]}}, w[31:12], 12'd0};

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  rv64_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(s1[31:0]), .divisor(s2[31:0]), .done(div_done), .rem(div_rem)
  );

  assign q_pop = state == S_IDLE && q_valid && (!out_valid || !out_stall);

  // execute result, combinational from registered operands
  always_comb begin
    o = '0;
    o.inst_pc = pc;
    o.next_pc = pc;
    npc = pc + 64'd4;
    we = 1'b0;
    widx = rd;
    wval = '0;
    if (halted) begin
      o.status = ST_IGNORED;
    end else if (cur.mode) begin
      if (load_pending) begin
        we = 1'b1;
        widx = load_dest;
        wval = load_is_word ? sx32(cur.load_data[31:0]) : cur.load_data;
      end
    end else if (load_pending) begin
      o.status = ST_NORMAL;
    end else if (cur.is_ebreak) begin
      o.status = ST_EBREAK;
      o.trap_code = a0;
    end else if (!cur.legal) begin
      o.status = ST_INVALID;
    end else begin
      unique case (w[6:0])
        OPC_LUI:   begin we = 1'b1; wval = immu; end
        OPC_AUIPC: begin we = 1'b1; wval = pc + immu; end
        OPC_JAL:   begin we = 1'b1; wval = pc + 64'd4; npc = pc + immj; end
        OPC_JALR:  begin
          we = 1'b1; wval = pc + 64'd4; npc = (s1 + immi) & ~64'd1;
        end
        OPC_BRANCH: begin
          if ((f3 == 3'd0 && s1 == s2) || (f3 == 3'd1 && s1 != s2)
              || (f3 == 3'd5 && $signed(s1) >= $signed(s2)))
            npc = pc + immb;
        end
        OPC_LOAD: begin
          o.mem_op = MEM_READ;
          o.mem_addr = s1 + immi;
          o.mem_size = f3 == 3'd2 ? 4'd4 : 4'd8;
        end
        OPC_STORE: begin
          o.mem_op = MEM_WRITE;
          o.mem_addr = s1 + imms;
          o.mem_size = f3 == 3'd2 ? 4'd4 : 4'd8;
          o.mem_wdata = f3 == 3'd2 ? {32'd0, s2[31:0]} : s2;
        end
        OPC_OPIMM: begin
          we = 1'b1;
          if (f3 == 3'd0) wval = s1 + immi;
          else if (f3 == 3'd3) wval = {63'd0, s1 < immi};
          else wval = s1 & immi;
        end
        OPC_OP:     begin we = 1'b1; wval = s1 - s2; end
        OPC_OPIMMW: begin we = 1'b1; wval = sx32(s1[31:0] + immi[31:0]); end
        default: begin
          we = 1'b1;
          if (w[25] == 1'b0) wval = sx32(s1[31:0] + s2[31:0]);
          else if (f3 == 3'd0) wval = sx32(mul_p[31:0]);
          else if (s2[31:0] == 32'd0) wval = sx32(s1[31:0]);
          else if (s2[31:0] == 32'hFFFF_FFFF) wval = '0;
          else wval = sx32(div_rem);
        end
      endcase
      o.next_pc = npc;
    end
    if (widx == '0) we = 1'b0;
    if (we) begin
      o.reg_write = 1'b1;
      o.reg_index = widx;
      o.reg_value = wval;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) rf[clr_idx] <= '0;
    else if (state == S_EXEC && we) rf[widx] <= wval;
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      s1 <= w[19:15] == 5'd0 ? '0 : rf[w[19:15]];
      s2 <= w[24:20] == 5'd0 ? '0 : rf[w[24:20]];
      a0 <= rf[10];
    end
    if (state == S_MUL) mul_p <= s1[31:0] * s2[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      pc <= reset_pc;
      halted <= 1'b0;
      load_pending <= 1'b0;
      load_dest <= '0;
      load_is_word <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == RW'(NUM_REGS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_pop) begin
          cur <= q_head;
          state <= S_READ;
        end
        S_READ: begin
          if (!halted && !cur.mode && !load_pending && cur.legal && !cur.is_ebreak
              && w[6:0] == OPC_OPW && w[25]) state <= f3 == 3'd0 ? S_MUL : S_DIV;
          else state <= S_EXEC;
        end
        S_MUL: state <= S_EXEC;
        S_DIV: if (div_done) state <= S_EXEC;
        default: begin
          out_word <= o;
          out_valid <= 1'b1;
          state <= S_IDLE;
          if (!halted) begin
            if (cur.mode) load_pending <= 1'b0;
            else if (!load_pending) begin
              if (cur.is_ebreak || !cur.legal) halted <= 1'b1;
              else begin
                pc <= npc;
                if (w[6:0] == OPC_LOAD) begin
                  load_pending <= 1'b1;
                  load_dest <= rd;
                  load_is_word <= f3 == 3'd2;
                end
              end
            end
          end
        end
      endcase
    end
  end

  // divider kicks off on entry to S_DIV
  always_ff @(posedge clk) begin
    if (rst) div_go <= 1'b0;
    else div_go <= state == S_READ && !halted && !cur.mode && !load_pending && cur.legal
                   && !cur.is_ebreak && w[6:0] == OPC_OPW && w[25] && f3 != 3'd0;
  end
  assign div_start = div_go;

  assert property (@(posedge clk) disable iff (rst) q_pop |-> state == S_IDLE)
    else $error("pop while busy");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> out_valid)
    else $error("no result after execute");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");

endmodule
`default_nettype wire

### rtl/rv64_subset_decode_execute_top.sv
// Top level of the RV64 subset decode/execute block.
// Depends on rv64_pkg, rv64_front, rv64_back, rv64_div.
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_stall    | in_word  (in_word_t)
//  out     | output    | out_valid / out_stall  | out_word (out_word_t)
//  cfg     | input     | cfg_we                 | cfg_wdata (reset_pc)
//
// Each word passes the back end states pop (S_IDLE), read and execute; its result is
// then offered while the next word can be popped, unless out_stall holds it.
// mulw adds the multiplier state S_MUL, remw the S_DIV wait for the bit-serial divider.
// After reset a sweep clears the register file before the back end takes words.
// reset_pc returns to its default at reset; a two-entry queue lets input flow while the
// back stalls.
`default_nettype none
module rv64_subset_decode_execute_top
  import rv64_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire in_word_t        in_word,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output out_word_t            out_word,
  input  wire logic            cfg_we,
  input  wire logic [XLEN-1:0] cfg_wdata
);

  logic [XLEN-1:0] reset_pc;
  logic            q_valid, q_pop;
  dec_word_t       q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_pc <= RESET_PC;
    end else if (cfg_we) begin
      reset_pc <= cfg_wdata;
    end
  end

  rv64_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_word, .q_valid, .q_pop, .q_head
  );

  rv64_back u_back (
    .clk, .rst, .reset_pc, .q_valid, .q_pop, .q_head, .out_valid, .out_stall, .out_word
  );

endmodule
`default_nettype wire

### dv/tb_rv64_subset_decode_execute_top.sv
// Self-checking bench for rv64_subset_decode_execute_top: directed and random instruction
// streams, load data and noise words, with a shadow core predicting every result word.
// Depends on rv64_pkg and the RTL under rtl/.
`default_nettype none
module tb_rv64_subset_decode_execute_top;
  import rv64_pkg::*;

  localparam int WATCHDOG = 3000;
  localparam int SETTLE = 60;
  localparam logic [2:0] F3_ADD = 3'd0, F3_SLTU = 3'd3, F3_AND = 3'd7, F3_BEQ = 3'd0;
  localparam logic [2:0] F3_BNE = 3'd1, F3_BGE = 3'd5, F3_WORD = 3'd2, F3_DBL = 3'd3;
  localparam logic [2:0] F3_REM = 3'd6;
  localparam logic [6:0] F7_BASE = 7'h00, F7_MUL = 7'h01, F7_SUB = 7'h20;
  localparam logic [31:0] WORD_BAD = 32'h0000_0000;

  typedef enum int {K_LUI, K_AUIPC, K_JAL, K_JALR, K_BEQ, K_BNE, K_BGE, K_LW, K_LD, K_SW,
                    K_SD, K_ADDI, K_SLTIU, K_ANDI, K_SUB, K_ADDIW, K_ADDW, K_MULW,
                    K_REMW} kind_e;

  typedef struct {
    in_word_t    w;
    bit          sync;
    logic [63:0] cfg_val;
  } stim_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;

  rv64_subset_decode_execute_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // shadow core
  logic [63:0] regs_q [32];
  logic [63:0] pc_q;
  logic [63:0] reset_pc_q;
  bit ld_pend, ld_word, halted_q;
  logic [4:0] ld_dest;

  stim_t words_q [$];
  out_word_t retire_q [$];
  bit failed, took, hold_done, gen_pend;
  int accepted_in, idle_cycles, gap, burst, settle, hold_left, stall_mode, stall_len;

  function automatic logic [63:0] sext32(logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  function automatic void put_reg(inout out_word_t o, input logic [4:0] i,
                                  input logic [63:0] v);
    if (i != 0) begin
      regs_q[i] = v;
      o.reg_write = 1'b1;
      o.reg_index = i;
      o.reg_value = v;
    end
  endfunction

  function automatic out_word_t execute_word(in_word_t iw);
    out_word_t o;
    logic [31:0] w;
    logic [6:0] opc, f7;
    logic [2:0] f3;
    logic [4:0] rd;
    logic [63:0] s1, s2, immi, imms, immb, immj, immu, nxt;
    logic signed [63:0] a, b;
    bit bad;
    w = iw.instruction;
    opc = w[6:0];
    f3 = w[14:12];
    f7 = w[31:25];
    rd = w[11:7];
    s1 = (w[19:15] == 0) ? '0 : regs_q[w[19:15]];
    s2 = (w[24:20] == 0) ? '0 : regs_q[w[24:20]];
    immi = {{52{w[31]}}, w[31:20]};
    imms = {{52{w[31]}}, w[31:25], w[11:7]};
    immb = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    immj = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    immu = {{32{w[31]}}, w[31:12], 12'b0};
    nxt = pc_q + 64'd4;
    bad = 1'b0;
    o = '0;
    o.inst_pc = pc_q;
    o.next_pc = pc_q;
    if (halted_q) begin
      o.status = ST_IGNORED;
      return o;
    end
    if (iw.mode) begin
      if (ld_pend) begin
        ld_pend = 1'b0;
        put_reg(o, ld_dest, ld_word ? sext32(iw.load_data) : iw.load_data);
      end
      return o;
    end
    if (ld_pend) return o;
    if (w == WORD_EBREAK) begin
      halted_q = 1'b1;
      o.status = ST_EBREAK;
      o.trap_code = regs_q[10];
      return o;
    end
    case (opc)
      OPC_LUI: put_reg(o, rd, immu);
      OPC_AUIPC: put_reg(o, rd, pc_q + immu);
      OPC_JAL: begin
        put_reg(o, rd, pc_q + 64'd4);
        nxt = pc_q + immj;
      end
      OPC_JALR: begin
        if (f3 != F3_ADD) bad = 1'b1;
        else begin
          nxt = (s1 + immi) & ~64'd1;
          put_reg(o, rd, pc_q + 64'd4);
        end
      end
      OPC_BRANCH: begin
        if (f3 == F3_BEQ) begin
          if (s1 == s2) nxt = pc_q + immb;
        end else if (f3 == F3_BNE) begin
          if (s1 != s2) nxt = pc_q + immb;
        end else if (f3 == F3_BGE) begin
          if ($signed(s1) >= $signed(s2)) nxt = pc_q + immb;
        end else bad = 1'b1;
      end
      OPC_LOAD: begin
        if (f3 != F3_WORD && f3 != F3_DBL) bad = 1'b1;
        else begin
          o.mem_op = MEM_READ;
          o.mem_addr = s1 + immi;
          o.mem_size = (f3 == F3_WORD) ? 4'd4 : 4'd8;
          ld_pend = 1'b1;
          ld_dest = rd;
          ld_word = (f3 == F3_WORD);
        end
      end
      OPC_STORE: begin
        if (f3 != F3_WORD && f3 != F3_DBL) bad = 1'b1;
        else begin
          o.mem_op = MEM_WRITE;
          o.mem_addr = s1 + imms;
          o.mem_size = (f3 == F3_WORD) ? 4'd4 : 4'd8;
          o.mem_wdata = (f3 == F3_WORD) ? {32'b0, s2[31:0]} : s2;
        end
      end
      OPC_OPIMM: begin
        if (f3 == F3_ADD) put_reg(o, rd, s1 + immi);
        else if (f3 == F3_SLTU) put_reg(o, rd, (s1 < immi) ? 64'd1 : 64'd0);
        else if (f3 == F3_AND) put_reg(o, rd, s1 & immi);
        else bad = 1'b1;
      end
      OPC_OP: begin
        if (f7 != F7_SUB || f3 != F3_ADD) bad = 1'b1;
        else put_reg(o, rd, s1 - s2);
      end
      OPC_OPIMMW: begin
        if (f3 != F3_ADD) bad = 1'b1;
        else put_reg(o, rd, sext32(s1 + immi));
      end
      OPC_OPW: begin
        if (f7 == F7_BASE && f3 == F3_ADD) put_reg(o, rd, sext32(s1 + s2));
        else if (f7 == F7_MUL && f3 == F3_ADD)
          put_reg(o, rd, sext32({32'b0, s1[31:0]} * {32'b0, s2[31:0]}));
        else if (f7 == F7_MUL && f3 == F3_REM) begin
          a = sext32(s1);
          b = sext32(s2);
          if (b == 0) put_reg(o, rd, a);
          else if (b == -64'sd1) put_reg(o, rd, '0);
          else put_reg(o, rd, sext32(a % b));
        end else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      halted_q = 1'b1;
      o.status = ST_INVALID;
      return o;
    end
    pc_q = nxt;
    o.next_pc = nxt;
    return o;
  endfunction

  // encoders
  function automatic logic [31:0] enc_i(logic [6:0] opc, logic [2:0] f3, logic [4:0] rd,
                                        logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [2:0] f3, logic [6:0] opc,
                                        logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                        logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                        logic [12:0] off);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] off);
    return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 11));
  endfunction

  task automatic push_inst(logic [31:0] w);
    stim_t s;
    s.w = '{mode: 1'b0, instruction: w, load_data: rand64()};
    s.sync = 1'b0;
    s.cfg_val = '0;
    words_q.push_back(s);
    if (w[6:0] == OPC_LOAD) gen_pend = 1'b1;
  endtask

  task automatic push_data(logic [63:0] d);
    stim_t s;
    s.w = '{mode: 1'b1, instruction: $urandom, load_data: d};
    s.sync = 1'b0;
    s.cfg_val = '0;
    words_q.push_back(s);
    gen_pend = 1'b0;
  endtask

  task automatic push_sync(logic [63:0] v);
    stim_t s;
    s.w = '0;
    s.sync = 1'b1;
    s.cfg_val = v;
    words_q.push_back(s);
  endtask

  task automatic push_random();
    kind_e k;
    logic [4:0] rd, r1, r2;
    logic [11:0] imm;
    k = kind_e'($urandom_range(0, 18));
    rd = pick_reg();
    r1 = pick_reg();
    r2 = pick_reg();
    imm = ($urandom_range(0, 1) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
    case (k)
      K_LUI: push_inst({20'($urandom), rd, OPC_LUI});
      K_AUIPC: push_inst({20'($urandom), rd, OPC_AUIPC});
      K_JAL: push_inst(enc_j(rd, 21'($urandom)));
      K_JALR: push_inst(enc_i(OPC_JALR, F3_ADD, rd, r1, imm));
      K_BEQ: push_inst(enc_b(F3_BEQ, r1, r2, 13'($urandom)));
      K_BNE: push_inst(enc_b(F3_BNE, r1, r2, 13'($urandom)));
      K_BGE: push_inst(enc_b(F3_BGE, r1, r2, 13'($urandom)));
      K_LW: push_inst(enc_i(OPC_LOAD, F3_WORD, rd, r1, imm));
      K_LD: push_inst(enc_i(OPC_LOAD, F3_DBL, rd, r1, imm));
      K_SW: push_inst(enc_s(F3_WORD, r1, r2, imm));
      K_SD: push_inst(enc_s(F3_DBL, r1, r2, imm));
      K_ADDI: push_inst(enc_i(OPC_OPIMM, F3_ADD, rd, r1, imm));
      K_SLTIU: push_inst(enc_i(OPC_OPIMM, F3_SLTU, rd, r1, imm));
      K_ANDI: push_inst(enc_i(OPC_OPIMM, F3_AND, rd, r1, imm));
      K_SUB: push_inst(enc_r(F7_SUB, F3_ADD, OPC_OP, rd, r1, r2));
      K_ADDIW: push_inst(enc_i(OPC_OPIMMW, F3_ADD, rd, r1, imm));
      K_ADDW: push_inst(enc_r(F7_BASE, F3_ADD, OPC_OPW, rd, r1, r2));
      K_MULW: push_inst(enc_r(F7_MUL, F3_ADD, OPC_OPW, rd, r1, r2));
      default: push_inst(enc_r(F7_MUL, F3_REM, OPC_OPW, rd, r1, r2));
    endcase
    if (gen_pend) begin
      if ($urandom_range(0, 9) == 0) push_inst($urandom);
      push_data(rand64());
    end else if ($urandom_range(0, 29) == 0) push_data(rand64());
  endtask

  // stimulus and end of run
  initial begin
    logic [63:0] cfg_vals [4];
    cfg_vals = '{64'h0, '1, {$urandom, $urandom}, 64'h8000_0000};
    push_inst({20'h80000, 5'd1, OPC_LUI});
    push_inst(enc_i(OPC_OPIMM, F3_ADD, 5'd2, 5'd0, 12'hFFF));
    push_inst(enc_r(F7_MUL, F3_REM, OPC_OPW, 5'd3, 5'd1, 5'd2));
    push_inst(enc_r(F7_MUL, F3_REM, OPC_OPW, 5'd4, 5'd1, 5'd0));
    push_inst(enc_i(OPC_OPIMMW, F3_ADD, 5'd5, 5'd1, 12'hFFF));
    push_inst(enc_r(F7_BASE, F3_ADD, OPC_OPW, 5'd6, 5'd5, 5'd5));
    push_inst(enc_r(F7_MUL, F3_ADD, OPC_OPW, 5'd7, 5'd1, 5'd2));
    push_inst(enc_r(F7_SUB, F3_ADD, OPC_OP, 5'd8, 5'd0, 5'd2));
    push_inst(enc_i(OPC_OPIMM, F3_SLTU, 5'd9, 5'd2, 12'hFFF));
    push_inst(enc_i(OPC_OPIMM, F3_AND, 5'd10, 5'd2, 12'h7FF));
    push_inst(enc_i(OPC_OPIMM, F3_ADD, 5'd0, 5'd1, 12'd5));
    push_inst(enc_s(F3_WORD, 5'd1, 5'd2, 12'hFFC));
    push_inst(enc_s(F3_DBL, 5'd0, 5'd2, 12'h7FF));
    push_inst(enc_i(OPC_LOAD, F3_WORD, 5'd12, 5'd0, 12'd0));
    push_data(64'hFFFF_FFFF_8000_0000);
    push_inst(enc_i(OPC_LOAD, F3_DBL, 5'd0, 5'd1, 12'h800));
    push_inst(32'hFFFF_FFFF);
    push_data('1);
    push_data(64'h1234);
    push_inst(enc_b(F3_BEQ, 5'd0, 5'd0, 13'd8));
    push_inst(enc_b(F3_BGE, 5'd1, 5'd0, 13'h1FF0));
    push_inst(enc_b(F3_BGE, 5'd0, 5'd1, 13'h1000));
    push_inst(enc_j(5'd13, 21'h100000));
    push_inst(enc_i(OPC_JALR, F3_ADD, 5'd14, 5'd1, 12'd1));
    push_inst({20'hFFFFF, 5'd15, OPC_AUIPC});
    for (int p = 0; p < 4; p++) begin
      push_sync(cfg_vals[p]);
      for (int i = 0; i < 410; i++) push_random();
    end
    push_sync({$urandom, $urandom});
    push_inst(($urandom_range(0, 1) == 0) ? WORD_EBREAK : WORD_BAD);
    push_inst(enc_i(OPC_OPIMM, F3_ADD, 5'd1, 5'd1, 12'd1));
    push_data('1);
    push_inst(WORD_EBREAK);
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    while (words_q.size() != 0 || in_valid || retire_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (!failed && retire_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // sender: bursts with gaps; sync entries drain the block and then write reset_pc
  always @(negedge clk) begin
    stim_t nxt_s;
    if (rst) begin
      in_valid = 1'b0;
      cfg_we = 1'b0;
    end else begin
      cfg_we = 1'b0;
      if (!in_valid || took) begin
        in_valid = 1'b0;
        if (gap > 0) gap--;
        else if (words_q.size() != 0) begin
          if (words_q[0].sync) begin
            if (retire_q.size() != 0) settle = 0;
            else if (settle < SETTLE) settle++;
            else begin
              cfg_we = 1'b1;
              cfg_wdata = words_q[0].cfg_val;
              reset_pc_q = words_q[0].cfg_val;
              void'(words_q.pop_front());
              settle = 0;
              gap = 1;
            end
          end else begin
            nxt_s = words_q.pop_front();
            in_word = nxt_s.w;
            in_valid = 1'b1;
            if (burst > 0) burst--;
            else begin
              burst = $urandom_range(0, 40);
              gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
          end
        end
      end
      took = 1'b0;
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(negedge clk) begin
    if (rst) out_stall = 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else if (!hold_done && accepted_in >= 400) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_stall = 1'b1;
    end else begin
      if (stall_len == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_len = $urandom_range(20, 120);
      end else stall_len--;
      case (stall_mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 3) == 0);
        default: out_stall = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      pc_q = 64'h8000_0000;
      reset_pc_q = 64'h8000_0000;
      foreach (regs_q[i]) regs_q[i] = '0;
      ld_pend = 1'b0;
      ld_word = 1'b0;
      ld_dest = '0;
      halted_q = 1'b0;
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        retire_q.push_back(execute_word(in_word));
        accepted_in++;
        took = 1'b1;
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (retire_q.size() == 0) begin
          $display("%0t unexpected word %h", $time, out_word);
          failed = 1'b1;
        end else begin
          e = retire_q.pop_front();
          check_field("inst_pc", e.inst_pc, out_word.inst_pc);
          check_field("next_pc", e.next_pc, out_word.next_pc);
          check_field("mem_op", 64'(e.mem_op), 64'(out_word.mem_op));
          check_field("mem_addr", e.mem_addr, out_word.mem_addr);
          check_field("mem_size", 64'(e.mem_size), 64'(out_word.mem_size));
          check_field("mem_wdata", e.mem_wdata, out_word.mem_wdata);
          check_field("reg_write", 64'(e.reg_write), 64'(out_word.reg_write));
          check_field("reg_index", 64'(e.reg_index), 64'(out_word.reg_index));
          check_field("reg_value", e.reg_value, out_word.reg_value);
          check_field("status", 64'(e.status), 64'(out_word.status));
          check_field("trap_code", e.trap_code, out_word.trap_code);
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t watchdog: no word moved for %0d cycles", $time, WATCHDOG);
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire

### rv64_subset_decode_execute_top.f
rtl/rv64_pkg.sv
rtl/rv64_front.sv
rtl/rv64_div.sv
rtl/rv64_back.sv
rtl/rv64_subset_decode_execute_top.sv
dv/tb_rv64_subset_decode_execute_top.sv
